// File: rtl/core/mpf_pkg.sv
// ----------------------------------------------------------------------------
// mpf_pkg
// Shared widths, constants and register addresses of the matrix peak finder.
// ----------------------------------------------------------------------------
`default_nettype none

package mpf_pkg;

  // Element and index widths fixed by the word format.
  localparam int DATA_W = 32;
  localparam int DIM_W  = 7;

  // Default matrix capacity.
  localparam int MAX_ROWS_DEF = 64;
  localparam int MAX_COLS_DEF = 64;

  // Configuration port geometry.
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  // Register index, taken from address bit 2.
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  // Reset value of both dimension registers.
  localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

  // Most negative element, used for neighbors outside the matrix.
  localparam logic signed [DATA_W-1:0] INT_MIN = 32'sh8000_0000;

  // Index reported when no strict peak exists.
  localparam logic signed [DIM_W-1:0] NO_PEAK_IDX = -7'sd1;

endpackage : mpf_pkg

`default_nettype wire

// File: rtl/core/mpf_in_if.sv
// ----------------------------------------------------------------------------
// mpf_in_if
// Element stream channel: one matrix element per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface mpf_in_if;
  import mpf_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] element_value;
  logic                     is_last;

  modport source (output valid, output element_value, output is_last, input ready);
  modport sink   (input valid, input element_value, input is_last, output ready);
endinterface : mpf_in_if

`default_nettype wire

// File: rtl/core/mpf_out_if.sv
// ----------------------------------------------------------------------------
// mpf_out_if
// Result channel: peak position and found flag, one word per matrix.
// ----------------------------------------------------------------------------
`default_nettype none

interface mpf_out_if;
  import mpf_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [DIM_W-1:0] peak_row;
  logic signed [DIM_W-1:0] peak_col;
  logic                    found;

  modport source (output valid, output peak_row, output peak_col, output found,
                  input ready);
  modport sink   (input valid, input peak_row, input peak_col, input found,
                  output ready);
endinterface : mpf_out_if

`default_nettype wire

// File: rtl/core/mpf_ram.sv
// ----------------------------------------------------------------------------
// mpf_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mpf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : mpf_ram

`default_nettype wire

// File: rtl/core/matrix_peak_finder_core.sv
// ----------------------------------------------------------------------------
// matrix_peak_finder_core
// Stores a row-major matrix and runs a binary search over its columns for a
// strict 2-D peak, reporting its row and column.
// ----------------------------------------------------------------------------
//
//   Port group   Role    Moves
//   in_ch        sink    one signed element per word, is_last ends the matrix
//   out_ch       source  peak_row, peak_col, found; one word per matrix
//   cfg_*        APB     rows_in_use at 0x0, cols_in_use at 0x4
//
// Elements load at one word per cycle into a single-port-read matrix RAM.
// After the last word, input is held off while the search runs: each search
// step issues one RAM read per row of the middle column, then reads the two
// neighbors of the column maximum, and there are at most log2(cols)+1 steps;
// a start state comes first, and S_OUT hands the result to the output register.
// Reset is synchronous; the matrix RAM is not cleared. A stalled result word
// waits in the output register and blocks only the next search from ending.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_peak_finder_core #(
  parameter int MAX_ROWS = mpf_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = mpf_pkg::MAX_COLS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  mpf_in_if.sink                         in_ch,
  mpf_out_if.source                      out_ch,
  input  wire logic                      cfg_psel,
  input  wire logic                      cfg_penable,
  input  wire logic                      cfg_pwrite,
  input  wire logic [mpf_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [mpf_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic      [mpf_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                           cfg_pready
);
  import mpf_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_LOAD, S_START, S_MID, S_COL, S_RDL, S_RDR, S_DEC, S_OUT
  } state_t;

  state_t                   state_r;
  logic [DIM_W-1:0]         rows_cfg_r;
  logic [DIM_W-1:0]         cols_cfg_r;
  logic [CNT_W-1:0]         load_count_r;
  logic signed [DIM_W:0]    low_r;
  logic signed [DIM_W:0]    high_r;
  logic [DIM_W-1:0]         mid_r;
  logic [DIM_W-1:0]         iss_row_r;
  logic [AW-1:0]            iss_addr_r;
  logic                     pend_valid_r;
  logic [DIM_W-1:0]         pend_row_r;
  logic [AW-1:0]            pend_addr_r;
  logic [DIM_W-1:0]         max_row_r;
  logic [AW-1:0]            max_addr_r;
  logic signed [DATA_W-1:0] max_value_r;
  logic signed [DATA_W-1:0] left_r;
  logic signed [DIM_W-1:0]  res_row_r;
  logic signed [DIM_W-1:0]  res_col_r;
  logic                     res_found_r;
  logic                     out_valid_r;
  logic signed [DIM_W-1:0]  out_row_r;
  logic signed [DIM_W-1:0]  out_col_r;
  logic                     out_found_r;

  logic [DIM_W-1:0]         rows_eff;
  logic [DIM_W-1:0]         cols_eff;
  logic [2*DIM_W-1:0]       total;
  logic                     in_fire;
  logic                     ram_we;
  logic [AW-1:0]            ram_raddr;
  logic [DATA_W-1:0]        ram_rdata;
  logic signed [DATA_W-1:0] rd_value;
  logic [DIM_W:0]           mid_sum;
  logic                     has_left;
  logic                     has_right;
  logic signed [DATA_W-1:0] right_value;
  logic                     cfg_wr;
  logic                     out_load;

  // Effective dimensions: zero acts as one, values above capacity saturate.
  always_comb begin
    if (rows_cfg_r == '0) begin
      rows_eff = DIM_W'(1);
    end else if (32'(rows_cfg_r) > 32'(MAX_ROWS)) begin
      rows_eff = DIM_W'(MAX_ROWS);
    end else begin
      rows_eff = rows_cfg_r;
    end
    if (cols_cfg_r == '0) begin
      cols_eff = DIM_W'(1);
    end else if (32'(cols_cfg_r) > 32'(MAX_COLS)) begin
      cols_eff = DIM_W'(MAX_COLS);
    end else begin
      cols_eff = cols_cfg_r;
    end
  end

  assign total = {{DIM_W{1'b0}}, rows_eff} * {{DIM_W{1'b0}}, cols_eff};

  // Load path: elements past the matrix size are dropped.
  assign in_ch.ready = (state_r == S_LOAD);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign ram_we      = in_fire && (32'(load_count_r) < 32'(total));

  // Search datapath helpers.
  assign rd_value    = $signed(ram_rdata);
  assign mid_sum     = {1'b0, low_r[DIM_W-1:0]} + {1'b0, high_r[DIM_W-1:0]};
  assign has_left    = (mid_r != '0);
  assign has_right   = ({1'b0, mid_r} + (DIM_W+1)'(1)) < {1'b0, cols_eff};
  assign right_value = has_right ? rd_value : INT_MIN;

  // The finished result moves to the output register once that is free.
  assign out_load    = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);

  // Read address selection per search state.
  always_comb begin
    ram_raddr = '0;
    unique case (state_r)
      S_COL:   ram_raddr = iss_addr_r;
      S_RDL:   ram_raddr = has_left ? (max_addr_r - AW'(1)) : max_addr_r;
      S_RDR:   ram_raddr = has_right ? (max_addr_r + AW'(1)) : max_addr_r;
      default: ram_raddr = '0;
    endcase
  end

  mpf_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_matrix_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (load_count_r[AW-1:0]),
    .wdata (in_ch.element_value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Configuration registers.
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  always_comb begin
    unique case (cfg_paddr[2])
      REG_ROWS: cfg_prdata = CFG_DW'(rows_cfg_r);
      REG_COLS: cfg_prdata = CFG_DW'(cols_cfg_r);
      default:  cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg_r <= DIM_RESET;
      cols_cfg_r <= DIM_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_ROWS: rows_cfg_r <= cfg_pwdata[DIM_W-1:0];
        REG_COLS: cols_cfg_r <= cfg_pwdata[DIM_W-1:0];
        default:  ;
      endcase
    end
  end

  // Control sequencer: load, column scan, neighbor check, result hand-off.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_LOAD;
      load_count_r <= '0;
      low_r        <= '0;
      high_r       <= '0;
      max_row_r    <= '0;
      max_value_r  <= INT_MIN;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      // Output register: take a new result or retire the one accepted.
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_LOAD: begin
          if (ram_we) begin
            load_count_r <= load_count_r + CNT_W'(1);
          end
          if (in_fire && in_ch.is_last) begin
            state_r <= S_START;
          end
        end
        S_START: begin
          low_r   <= '0;
          high_r  <= $signed({1'b0, cols_eff}) - (DIM_W+1)'(1);
          state_r <= S_MID;
        end
        S_MID: begin
          if (low_r > high_r) begin
            res_row_r   <= NO_PEAK_IDX;
            res_col_r   <= NO_PEAK_IDX;
            res_found_r <= 1'b0;
            state_r     <= S_OUT;
          end else begin
            mid_r        <= mid_sum[DIM_W:1];
            iss_row_r    <= '0;
            iss_addr_r   <= AW'(mid_sum[DIM_W:1]);
            pend_valid_r <= 1'b0;
            state_r      <= S_COL;
          end
        end
        S_COL: begin
          // Issue one row read per cycle down the middle column.
          if (iss_row_r < rows_eff) begin
            pend_valid_r <= 1'b1;
            pend_row_r   <= iss_row_r;
            pend_addr_r  <= iss_addr_r;
            iss_row_r    <= iss_row_r + DIM_W'(1);
            iss_addr_r   <= iss_addr_r + AW'(cols_eff);
          end else begin
            pend_valid_r <= 1'b0;
          end
          // Track the first strict maximum as read data returns.
          if (pend_valid_r) begin
            if (pend_row_r == '0 || rd_value > max_value_r) begin
              max_value_r <= rd_value;
              max_row_r   <= pend_row_r;
              max_addr_r  <= pend_addr_r;
            end
            if (pend_row_r == rows_eff - DIM_W'(1)) begin
              state_r <= S_RDL;
            end
          end
        end
        S_RDL: begin
          state_r <= S_RDR;
        end
        S_RDR: begin
          left_r  <= has_left ? rd_value : INT_MIN;
          state_r <= S_DEC;
        end
        S_DEC: begin
          if (max_value_r > left_r && max_value_r > right_value) begin
            res_row_r   <= $signed(max_row_r);
            res_col_r   <= $signed(mid_r);
            res_found_r <= 1'b1;
            state_r     <= S_OUT;
          end else if (max_value_r < left_r) begin
            high_r  <= $signed({1'b0, mid_r}) - (DIM_W+1)'(1);
            state_r <= S_MID;
          end else begin
            low_r   <= $signed({1'b0, mid_r}) + (DIM_W+1)'(1);
            state_r <= S_MID;
          end
        end
        S_OUT: begin
          // Hand the result over once the output register is free.
          if (out_load) begin
            out_row_r    <= res_row_r;
            out_col_r    <= res_col_r;
            out_found_r  <= res_found_r;
            load_count_r <= '0;
            state_r      <= S_LOAD;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.peak_row = out_row_r;
  assign out_ch.peak_col = out_col_r;
  assign out_ch.found    = out_found_r;

  // The word after a last element is never taken while the search runs.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.is_last) |=> !in_ch.ready)
    else $error("input accepted right after the last element");

  // A failed search always reports minus one for both indices.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |->
      (out_row_r == NO_PEAK_IDX && out_col_r == NO_PEAK_IDX))
    else $error("no-peak result with a valid index");

  // The matrix RAM is written only while loading.
  assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_LOAD))
    else $error("matrix RAM written during search");

endmodule : matrix_peak_finder_core

`default_nettype wire

// File: dv/tb_matrix_peak_finder_core.sv
// ----------------------------------------------------------------------------
// tb_matrix_peak_finder_core
// Self-checking bench for the matrix peak finder. Matrices of many shapes and
// value patterns (plateaus, all-minimum columns, gradients, extremes) are
// streamed in one word at a time. Matrices ended early or overrun are mixed in.
// A local model of the column binary search predicts each result word, and the
// monitor compares every result field with the oldest prediction. The sender
// and the receiver stall at random. The dimension registers are rewritten
// between phases, only while the block is idle.
// ----------------------------------------------------------------------------

module tb_matrix_peak_finder_core;
  timeunit 1ns;
  timeprecision 1ps;

  import mpf_pkg::*;

  localparam int STORE_DEPTH = MAX_ROWS_DEF * MAX_COLS_DEF;
  localparam int MAX_DIM     = MAX_ROWS_DEF;
  // Longest search: 7 steps, each reading a whole column, plus start-up and hand-off.
  localparam int SETTLE_CYC  = 600;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int MIN_WORDS   = 800;
  localparam int MIN_MATS    = 30;
  localparam int SEND_LIGHT_END = 300;
  localparam int SEND_HEAVY_END = 600;
  localparam logic signed [DATA_W-1:0] ELEM_MAX = {1'b0, {(DATA_W-1){1'b1}}};

  typedef enum int {
    IDLE_SEND_LIGHT,
    IDLE_SEND_HEAVY,
    IDLE_NONE
  } idle_mode_e;

  typedef enum int {
    FILL_RANDOM,
    FILL_SMALL,
    FILL_FLAT,
    FILL_MINHEAVY,
    FILL_RISING,
    FILL_FALLING
  } fill_kind_e;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } elem_word_t;

  typedef struct {
    logic signed [DIM_W-1:0] row;
    logic signed [DIM_W-1:0] col;
    logic                    found;
  } peak_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  mpf_in_if  in_bus ();
  mpf_out_if out_bus ();

  matrix_peak_finder_core u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_bus),
    .out_ch      (out_bus),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Clock: 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Local copy of the block's state and registers.
  logic signed [DATA_W-1:0] matrix_copy [STORE_DEPTH];
  logic [DIM_W-1:0]         rows_reg = DIM_RESET;
  logic [DIM_W-1:0]         cols_reg = DIM_RESET;
  int                       load_cnt = 0;

  // Queues and counters shared by the processes.
  elem_word_t word_backlog [$];
  peak_t      pending_peaks [$];
  int         words_queued = 0;
  int         words_taken  = 0;
  int         mats_queued  = 0;
  int         fail_cnt     = 0;
  int         cycle_cnt    = 0;
  bit         in_taken     = 1'b0;

  // Stimulus-side bookkeeping of which store entries hold data.
  bit written_map [STORE_DEPTH];
  int gen_load  = 0;
  int gen_total = 1;
  int gen_rows  = 1;
  int gen_cols  = 1;

  // Register value to effective dimension: zero acts as one, large saturates.
  function automatic int dim_of(input logic [DIM_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  function automatic logic signed [DATA_W-1:0] elem_at(input int r, input int c,
                                                       input int ncols);
    int a;
    a = r * ncols + c;
    if (a >= STORE_DEPTH) return '0;
    return matrix_copy[a];
  endfunction

  // Store one word; on the last word run the column binary search.
  task automatic track_word(input logic signed [DATA_W-1:0] value, input logic last);
    int rows, cols, lo, hi, mid, mrow, r;
    bit done;
    logic signed [DATA_W-1:0] here, left, right, v;
    peak_t res;
    rows = dim_of(rows_reg);
    cols = dim_of(cols_reg);
    if (load_cnt < rows * cols) begin
      matrix_copy[load_cnt] = value;
      load_cnt++;
    end
    if (last) begin
      res.row   = NO_PEAK_IDX;
      res.col   = NO_PEAK_IDX;
      res.found = 1'b0;
      lo   = 0;
      hi   = cols - 1;
      done = 1'b0;
      while (lo <= hi && !done) begin
        mid  = (lo + hi) / 2;
        // First strict maximum of the middle column; row 0 if all are minimum.
        mrow = 0;
        here = elem_at(0, mid, cols);
        for (r = 1; r < rows; r++) begin
          v = elem_at(r, mid, cols);
          if (v > here) begin
            here = v;
            mrow = r;
          end
        end
        left  = (mid >= 1) ? elem_at(mrow, mid - 1, cols) : INT_MIN;
        right = (mid + 1 < cols) ? elem_at(mrow, mid + 1, cols) : INT_MIN;
        if (here > left && here > right) begin
          res.row   = mrow[DIM_W-1:0];
          res.col   = mid[DIM_W-1:0];
          res.found = 1'b1;
          done      = 1'b1;
        end else if (here < left) begin
          hi = mid - 1;
        end else begin
          lo = mid + 1;
        end
      end
      load_cnt = 0;
      pending_peaks.push_back(res);
    end
  endtask

  function automatic idle_mode_e idle_mode();
    if (words_taken < SEND_LIGHT_END) return IDLE_SEND_LIGHT;
    if (words_taken < SEND_HEAVY_END) return IDLE_SEND_HEAVY;
    return IDLE_NONE;
  endfunction

  // Sample both channels at the rising edge: predict on input, check on output.
  always @(posedge clk) begin : sample_blk
    peak_t want;
    cycle_cnt++;
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready) begin
        in_taken = 1'b1;
        words_taken++;
        track_word(in_bus.element_value, in_bus.is_last);
      end
      if (out_bus.valid && out_bus.ready) begin
        if (pending_peaks.size() == 0) begin
          $error("result word with no prediction: peak_row %0d peak_col %0d found %0d",
                 out_bus.peak_row, out_bus.peak_col, out_bus.found);
          fail_cnt++;
        end else begin
          want = pending_peaks.pop_front();
          if (out_bus.peak_row !== want.row) begin
            $error("peak_row: expected %0d, actual %0d", want.row, out_bus.peak_row);
            fail_cnt++;
          end
          if (out_bus.peak_col !== want.col) begin
            $error("peak_col: expected %0d, actual %0d", want.col, out_bus.peak_col);
            fail_cnt++;
          end
          if (out_bus.found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, out_bus.found);
            fail_cnt++;
          end
        end
      end
    end
  end

  // Element driver: presents the next backlog word at the falling edge.
  always @(negedge clk) begin : drive_blk
    elem_word_t nxt;
    bit gap;
    if (rst_n) begin
      if (!in_bus.valid || in_taken) begin
        case (idle_mode())
          IDLE_SEND_LIGHT: gap = ($urandom_range(0, 99) < 20);
          IDLE_SEND_HEAVY: gap = ($urandom_range(0, 99) < 48);
          default:         gap = 1'b0;
        endcase
        if (word_backlog.size() != 0 && !gap) begin
          nxt = word_backlog.pop_front();
          in_bus.element_value <= nxt.value;
          in_bus.is_last       <= nxt.last;
          in_bus.valid         <= 1'b1;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
      in_taken = 1'b0;
    end
  end

  // Result receiver: ready stalls at random at the falling edge.
  always @(negedge clk) begin
    case (idle_mode())
      IDLE_SEND_LIGHT: out_bus.ready <= ($urandom_range(0, 99) >= 48);
      IDLE_SEND_HEAVY: out_bus.ready <= ($urandom_range(0, 99) >= 20);
      default:         out_bus.ready <= 1'b1;
    endcase
  end

  // Watchdog on the cycle counter.
  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk);
    $display("status: fail");
    $finish;
  end

  // Queue one element word and note which store entry it fills.
  task automatic push_word(input logic signed [DATA_W-1:0] value, input logic last);
    elem_word_t w;
    w.value = value;
    w.last  = last;
    word_backlog.push_back(w);
    words_queued++;
    if (gen_load < gen_total) begin
      written_map[gen_load] = 1'b1;
      gen_load++;
    end
    if (last) begin
      gen_load = 0;
      mats_queued++;
    end
  endtask

  // APB write: setup cycle, then access cycle until pready.
  task automatic write_reg(input logic idx, input logic [DIM_W-1:0] dim);
    logic [CFG_DW-1:0] data;
    data = $urandom;
    data[DIM_W-1:0] = dim;
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (idx == REG_COLS) cols_reg = dim;
    else rows_reg = dim;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic configure(input logic [DIM_W-1:0] rows_v, input logic [DIM_W-1:0] cols_v);
    write_reg(REG_ROWS, rows_v);
    write_reg(REG_COLS, cols_v);
    gen_rows  = dim_of(rows_v);
    gen_cols  = dim_of(cols_v);
    gen_total = gen_rows * gen_cols;
  endtask

  // Hold the sender until every result has come, then let the search settle.
  task automatic drain_and_settle();
    while (words_taken < words_queued || pending_peaks.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  // Register encoding of a dimension, using the aliases of one and of the maximum.
  function automatic logic [DIM_W-1:0] encode_dim(input int d);
    int sel;
    sel = $urandom_range(0, 2);
    if (d == 1 && sel == 0) return '0;
    if (d == MAX_DIM && sel == 1) return 7'd127;
    if (d == MAX_DIM && sel == 2) return 7'($urandom_range(65, 126));
    return 7'(d);
  endfunction

  // One matrix of the current shape, full, ended early or overrun.
  task automatic gen_matrix();
    int n, c, i, sel;
    bit all_written;
    bit [63:0] min_cols;
    fill_kind_e kind;
    logic signed [DATA_W-1:0] flat, v;
    kind     = fill_kind_e'($urandom_range(0, 5));
    flat     = $urandom;
    min_cols = {$urandom, $urandom} & {$urandom, $urandom};
    all_written = 1'b1;
    for (i = 0; i < gen_total; i++) begin
      if (!written_map[i]) all_written = 1'b0;
    end
    sel = $urandom_range(0, 9);
    // An early last word is only legal once every entry of the shape holds data.
    if (sel == 0 && all_written && gen_total > 1) n = $urandom_range(1, gen_total - 1);
    else if (sel == 1) n = gen_total + $urandom_range(1, 3);
    else n = gen_total;
    for (i = 0; i < n; i++) begin
      c = i % gen_cols;
      case (kind)
        FILL_SMALL: v = $urandom_range(0, 2);
        FILL_FLAT:  v = flat;
        FILL_MINHEAVY: begin
          if (min_cols[c]) begin
            v = INT_MIN;
          end else begin
            case ($urandom_range(0, 3))
              0:       v = INT_MIN;
              1:       v = ELEM_MAX;
              2:       v = $urandom_range(0, 3);
              default: v = $urandom;
            endcase
          end
        end
        FILL_RISING:  v = c * 64 + $urandom_range(0, 3);
        FILL_FALLING: v = $urandom_range(0, 3) - c * 64;
        default:      v = $urandom;
      endcase
      push_word(v, i == n - 1);
    end
  endtask

  // Main sequence: reset, directed cases, then random phases.
  initial begin : main_seq
    int shape, nmat, m, rows_d, cols_d;
    in_bus.valid         = 1'b0;
    in_bus.element_value = '0;
    in_bus.is_last       = 1'b0;
    out_bus.ready        = 1'b0;
    cfg_psel             = 1'b0;
    cfg_penable          = 1'b0;
    cfg_pwrite           = 1'b0;
    cfg_paddr            = '0;
    cfg_pwdata           = '0;
    for (m = 0; m < STORE_DEPTH; m++) written_map[m] = 1'b0;

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Zero registers act as a 1x1 matrix: maximum value, minimum value, overrun.
    configure('0, '0);
    push_word(ELEM_MAX, 1'b1);
    push_word(INT_MIN, 1'b1);
    push_word(32'sd7, 1'b0);
    push_word(INT_MIN, 1'b0);
    push_word(ELEM_MAX, 1'b1);
    drain_and_settle();

    // 2x3: a flat plateau, an all-minimum middle column, then an early last word.
    configure(7'd2, 7'd3);
    for (m = 0; m < 6; m++) push_word(-32'sd1, m == 5);
    push_word(32'sd5, 1'b0);
    push_word(INT_MIN, 1'b0);
    push_word(32'sd4, 1'b0);
    push_word(32'sd1, 1'b0);
    push_word(INT_MIN, 1'b0);
    push_word(32'sd9, 1'b1);
    push_word(32'sd100, 1'b0);
    push_word(32'sd100, 1'b1);
    drain_and_settle();

    // Random phases, each with its own shape.
    while (words_queued < MIN_WORDS || mats_queued < MIN_MATS) begin
      shape = $urandom_range(0, 9);
      if (shape < 7) begin
        rows_d = $urandom_range(1, 6);
        cols_d = $urandom_range(1, 6);
        nmat   = $urandom_range(3, 6);
      end else if (shape == 7) begin
        rows_d = MAX_DIM;
        cols_d = $urandom_range(1, 2);
        nmat   = 2;
      end else if (shape == 8) begin
        rows_d = $urandom_range(1, 2);
        cols_d = MAX_DIM;
        nmat   = 2;
      end else begin
        rows_d = $urandom_range(7, 12);
        cols_d = $urandom_range(7, 12);
        nmat   = 2;
      end
      configure(encode_dim(rows_d), encode_dim(cols_d));
      for (m = 0; m < nmat; m++) gen_matrix();
      drain_and_settle();
    end

    if (fail_cnt == 0 && pending_peaks.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule : tb_matrix_peak_finder_core

// File: filelist.f
rtl/core/mpf_pkg.sv
rtl/core/mpf_in_if.sv
rtl/core/mpf_out_if.sv
rtl/core/mpf_ram.sv
rtl/core/matrix_peak_finder_core.sv
dv/tb_matrix_peak_finder_core.sv
